// ===== hdl/acmp_pkg.sv =====
package acmp_pkg;

  // operation codes
  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_TICK   = 3'd2;
  localparam logic [2:0] OP_EVAL   = 3'd3;
  localparam logic [2:0] OP_IRQ_ACK = 3'd4;

  // register indexes on the bus
  localparam logic [2:0] REG_CTRL    = 3'd0;
  localparam logic [2:0] REG_MUX     = 3'd1;
  localparam logic [2:0] REG_DAC     = 3'd2;
  localparam logic [2:0] REG_INTCTRL = 3'd3;
  localparam logic [2:0] REG_STATUS  = 3'd4;

  // configuration register indexes
  localparam logic CFG_VREF_MV = 1'b0;
  localparam logic CFG_EV_WIRED = 1'b1;

  // hysteresis codes, ctrl bits 2:1
  localparam logic [1:0] HYS_NONE = 2'd0;
  localparam logic [1:0] HYS_10   = 2'd1;
  localparam logic [1:0] HYS_25   = 2'd2;
  localparam logic [1:0] HYS_50   = 2'd3;

  // hysteresis in 1/256 mV
  localparam logic [13:0] HYS_10_Q8 = 14'd2560;
  localparam logic [13:0] HYS_25_Q8 = 14'd6400;
  localparam logic [13:0] HYS_50_Q8 = 14'd12800;

  // flag edge modes, ctrl bits 5:4
  localparam logic [1:0] EDGE_BOTH = 2'd0;
  localparam logic [1:0] EDGE_NONE = 2'd1;
  localparam logic [1:0] EDGE_FALL = 2'd2;
  localparam logic [1:0] EDGE_RISE = 2'd3;

  // negative mux code that selects the dac
  localparam logic [1:0] NEG_SEL_DAC = 2'd3;

  // reset values
  localparam logic [12:0] VREF_RESET = 13'd5000;
  localparam logic [7:0]  DAC_RESET  = 8'hFF;

endpackage

// ===== hdl/analog_comparator_with_hysteresis.sv =====
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_stall    | op, reg_index, wdata, pos_mv, neg_mv
// out     | output    | out_valid / out_stall  | rdata, irq, interrupt_taken, event_valid,
//         |           |                        | event_level, pos_select, neg_select
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one beat per cycle sustained while out_stall is low; a beat passes the input register, then the result register
// a beat sits in the input register, then one pass of compare and register update loads
// the result register and the block state at the same edge
// rst_n is synchronous, active low; the cfg port is always ready
// a stalled result holds; the input register still takes a beat while the result waits, if it is empty
module analog_comparator_with_hysteresis
  import acmp_pkg::*;
#(
  parameter int SETTLE_TICKS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [2:0]  in_reg_index,
  input  logic [7:0]  in_wdata,
  input  logic [12:0] in_pos_mv,
  input  logic [12:0] in_neg_mv,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_rdata,
  output logic        out_irq,
  output logic        out_interrupt_taken,
  output logic        out_event_valid,
  output logic        out_event_level,
  output logic [2:0]  out_pos_select,
  output logic [1:0]  out_neg_select,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);

  localparam logic [3:0] SETTLE_INIT = 4'(SETTLE_TICKS);

  // config registers
  logic [12:0] vref_mv_r;
  logic        ev_wired_r;

  // peripheral registers
  logic [7:0] ctrl_r, ctrl_nxt;
  logic [7:0] mux_r, mux_nxt;
  logic [7:0] dac_r, dac_nxt;
  logic [7:0] int_en_r, int_en_nxt;
  logic       flag_r, flag_nxt;
  logic       level_r, level_nxt;
  logic [3:0] settle_r, settle_nxt;

  // input register
  logic        s1_valid_r;
  logic [2:0]  s1_op_r;
  logic [2:0]  s1_idx_r;
  logic [7:0]  s1_wdata_r;
  logic [12:0] s1_pos_r;
  logic [12:0] s1_neg_r;

  // result register
  logic       out_valid_r;
  logic [7:0] rdata_r, rdata_nxt;
  logic       irq_r;
  logic       taken_r, taken_nxt;
  logic       ev_valid_r, ev_valid_nxt;
  logic       ev_level_r, ev_level_nxt;
  logic [2:0] pos_sel_r;
  logic [1:0] neg_sel_r;

  logic        advance;
  logic        active;
  logic [20:0] pos_q8;
  logic [20:0] neg_q8;
  logic [13:0] hys_q8;
  logic [21:0] lhs;
  logic [21:0] rhs;
  logic        lvl;
  logic        commit;
  logic        trig;

  // handshake
  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !advance;
  assign cfg_ready = 1'b1;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vref_mv_r  <= VREF_RESET;
      ev_wired_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_VREF_MV:  vref_mv_r  <= cfg_data;
        CFG_EV_WIRED: ev_wired_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_op_r    <= in_op;
      s1_idx_r   <= in_reg_index;
      s1_wdata_r <= in_wdata;
      s1_pos_r   <= in_pos_mv;
      s1_neg_r   <= in_neg_mv;
    end
  end

  // both sides in 1/256 mV
  assign active = ctrl_r[0] && !ctrl_r[3];
  assign pos_q8 = {s1_pos_r, 8'd0};
  assign neg_q8 = (mux_r[1:0] == NEG_SEL_DAC) ? ({13'd0, dac_r} * {8'd0, vref_mv_r})
                                              : {s1_neg_r, 8'd0};

  always_comb begin
    case (ctrl_r[2:1])
      HYS_10:  hys_q8 = HYS_10_Q8;
      HYS_25:  hys_q8 = HYS_25_Q8;
      HYS_50:  hys_q8 = HYS_50_Q8;
      default: hys_q8 = '0;
    endcase
  end

  // hysteresis moves the threshold away from the committed level
  assign lhs = {1'b0, pos_q8} + (level_r ? {8'd0, hys_q8} : 22'd0);
  assign rhs = {1'b0, neg_q8} + (level_r ? 22'd0 : {8'd0, hys_q8});
  assign lvl = (lhs > rhs) ^ mux_r[7];

  // settle counter and commit
  always_comb begin
    settle_nxt = settle_r;
    commit     = 1'b0;
    if (lvl == level_r) begin
      settle_nxt = '0;
    end else if (settle_r != '0) begin
      settle_nxt = settle_r - 4'd1;
      commit     = (settle_r == 4'd1);
    end else begin
      settle_nxt = SETTLE_INIT;
      commit     = (SETTLE_INIT == '0);
    end
  end

  always_comb begin
    case (ctrl_r[5:4])
      EDGE_BOTH: trig = 1'b1;
      EDGE_FALL: trig = !lvl;
      EDGE_RISE: trig = lvl;
      default:   trig = 1'b0;
    endcase
  end

  // per-operation register update
  always_comb begin
    ctrl_nxt     = ctrl_r;
    mux_nxt      = mux_r;
    dac_nxt      = dac_r;
    int_en_nxt   = int_en_r;
    flag_nxt     = flag_r;
    level_nxt    = level_r;
    rdata_nxt    = '0;
    taken_nxt    = 1'b0;
    ev_valid_nxt = 1'b0;
    ev_level_nxt = 1'b0;
    case (s1_op_r)
      OP_READ: begin
        case (s1_idx_r)
          REG_CTRL:    rdata_nxt = ctrl_r;
          REG_MUX:     rdata_nxt = mux_r;
          REG_DAC:     rdata_nxt = dac_r;
          REG_INTCTRL: rdata_nxt = int_en_r;
          REG_STATUS:  rdata_nxt = {3'd0, level_r, 3'd0, flag_r};
          default:     rdata_nxt = '0;
        endcase
      end
      OP_WRITE: begin
        case (s1_idx_r)
          REG_CTRL:    ctrl_nxt   = s1_wdata_r;
          REG_MUX:     mux_nxt    = s1_wdata_r;
          REG_DAC:     dac_nxt    = s1_wdata_r;
          REG_INTCTRL: int_en_nxt = s1_wdata_r;
          REG_STATUS: begin
            if (s1_wdata_r[0]) begin
              flag_nxt = 1'b0;
            end
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        if (active && commit) begin
          level_nxt = lvl;
          if (trig) begin
            flag_nxt = 1'b1;
          end
          if (ev_wired_r && ctrl_r[6]) begin
            ev_valid_nxt = 1'b1;
            ev_level_nxt = lvl;
          end
        end
      end
      OP_IRQ_ACK: begin
        if (int_en_r[0] && flag_r) begin
          flag_nxt  = 1'b0;
          taken_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // state commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r   <= '0;
      mux_r    <= '0;
      dac_r    <= DAC_RESET;
      int_en_r <= '0;
      flag_r   <= 1'b0;
      level_r  <= 1'b0;
      settle_r <= '0;
    end else if (advance && s1_valid_r) begin
      ctrl_r   <= ctrl_nxt;
      mux_r    <= mux_nxt;
      dac_r    <= dac_nxt;
      int_en_r <= int_en_nxt;
      flag_r   <= flag_nxt;
      level_r  <= level_nxt;
      if (s1_op_r == OP_TICK && active) begin
        settle_r <= settle_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      rdata_r    <= rdata_nxt;
      irq_r      <= int_en_nxt[0] && flag_nxt;
      taken_r    <= taken_nxt;
      ev_valid_r <= ev_valid_nxt;
      ev_level_r <= ev_level_nxt;
      pos_sel_r  <= mux_nxt[5:3];
      neg_sel_r  <= mux_nxt[1:0];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_rdata           = rdata_r;
  assign out_irq             = irq_r;
  assign out_interrupt_taken = taken_r;
  assign out_event_valid     = ev_valid_r;
  assign out_event_level     = ev_level_r;
  assign out_pos_select      = pos_sel_r;
  assign out_neg_select      = neg_sel_r;

  // an acknowledge that took the request leaves no request behind
  a_taken_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_interrupt_taken |-> !out_irq)
    else $error("interrupt taken but irq still set");

  // an event level is only sent with an event
  a_event_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_level |-> out_event_valid)
    else $error("event level without event");

  // settle count never exceeds its load value
  a_settle_range: assert property (@(posedge clk) disable iff (!rst_n)
    settle_r <= SETTLE_INIT)
    else $error("settle count out of range");

  // committed level only moves on a tick beat
  a_level_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !(advance && s1_valid_r && s1_op_r == OP_TICK) |=> $stable(level_r))
    else $error("level changed outside a tick");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import acmp_pkg::*;

  localparam int SETTLE = 2;

  // codes the block treats as unused
  localparam logic [2:0] OP_FIRST_UNUSED  = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED   = 3'd7;
  localparam logic [2:0] REG_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] REG_LAST_UNUSED  = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  reg_index;
    logic [7:0]  wdata;
    logic [12:0] pos_mv;
    logic [12:0] neg_mv;
  } bus_item_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
    logic       taken;
    logic       ev_valid;
    logic       ev_level;
    logic [2:0] pos_sel;
    logic [1:0] neg_sel;
  } acmp_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_op = '0;
  logic [2:0]  in_reg_index = '0;
  logic [7:0]  in_wdata = '0;
  logic [12:0] in_pos_mv = '0;
  logic [12:0] in_neg_mv = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_rdata;
  logic        out_irq;
  logic        out_interrupt_taken;
  logic        out_event_valid;
  logic        out_event_level;
  logic [2:0]  out_pos_select;
  logic [1:0]  out_neg_select;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [12:0] cfg_data = '0;

  // comparator mirror: bus registers, settle state and configuration
  logic [7:0]  m_ctrl = '0;
  logic [7:0]  m_mux = '0;
  logic [7:0]  m_dac = DAC_RESET;
  logic [7:0]  m_inten = '0;
  logic [7:0]  m_status = '0;
  logic        m_pending = 1'b0;
  logic [3:0]  m_settle = '0;
  logic [12:0] m_vref = VREF_RESET;
  logic        m_wired = 1'b0;

  // register values as the stimulus generator will leave them
  logic [7:0]  gen_mux = '0;
  logic [7:0]  gen_dac = DAC_RESET;
  logic [12:0] gen_vref = VREF_RESET;

  bus_item_t    pending_q[$];
  acmp_result_t result_q[$];
  bus_item_t    beat;
  bus_item_t    seen;
  acmp_result_t want;
  logic         in_taken = 1'b0;
  int           in_gap = 0;
  int           stall_left = 0;
  int           idle_pct = 0;
  int           stall_pct = 0;
  int           mismatch_count = 0;

  analog_comparator_with_hysteresis #(.SETTLE_TICKS(SETTLE)) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_reg_index        (in_reg_index),
    .in_wdata            (in_wdata),
    .in_pos_mv           (in_pos_mv),
    .in_neg_mv           (in_neg_mv),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_rdata           (out_rdata),
    .out_irq             (out_irq),
    .out_interrupt_taken (out_interrupt_taken),
    .out_event_valid     (out_event_valid),
    .out_event_level     (out_event_level),
    .out_pos_select      (out_pos_select),
    .out_neg_select      (out_neg_select),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int wanted);
    if (mismatch_count < 100) begin
      $display("%0t mismatch %s: got %0h, wanted %0h", $time, what, got, wanted);
    end
    mismatch_count++;
  endtask

  function automatic logic block_active();
    return m_ctrl[0] && !m_ctrl[3];
  endfunction

  // compare in 1/256 mV with hysteresis around the committed level, then invert if mux bit 7 is set
  function automatic logic compare_level(input logic [12:0] pos, input logic [12:0] neg);
    int   p;
    int   n;
    int   h;
    logic lvl;
    p = int'(pos) * 256;
    if (m_mux[1:0] == NEG_SEL_DAC) n = int'(m_dac) * int'(m_vref);
    else n = int'(neg) * 256;
    case (m_ctrl[2:1])
      HYS_10:  h = int'(HYS_10_Q8);
      HYS_25:  h = int'(HYS_25_Q8);
      HYS_50:  h = int'(HYS_50_Q8);
      default: h = 0;
    endcase
    if (m_ctrl[2:1] == HYS_NONE) lvl = p > n;
    else if (m_status[4]) lvl = p > n - h;
    else lvl = p > n + h;
    if (m_mux[7]) lvl = !lvl;
    return lvl;
  endfunction

  // one bus beat through the mirror, returning the result beat it causes
  function automatic acmp_result_t comparator_step(input bus_item_t it);
    acmp_result_t r;
    logic         commit;
    logic         trig;
    r = '0;
    commit = 1'b0;
    case (it.op)
      OP_READ: begin
        case (it.reg_index)
          REG_CTRL:    r.rdata = m_ctrl;
          REG_MUX:     r.rdata = m_mux;
          REG_DAC:     r.rdata = m_dac;
          REG_INTCTRL: r.rdata = m_inten;
          REG_STATUS:  r.rdata = m_status;
          default:     r.rdata = '0;
        endcase
      end
      OP_WRITE: begin
        case (it.reg_index)
          REG_CTRL:    m_ctrl = it.wdata;
          REG_MUX:     m_mux = it.wdata;
          REG_DAC:     m_dac = it.wdata;
          REG_INTCTRL: m_inten = it.wdata;
          REG_STATUS:  if (it.wdata[0]) m_status[0] = 1'b0;
          default:     ;
        endcase
      end
      OP_TICK: begin
        if (block_active()) begin
          m_pending = compare_level(it.pos_mv, it.neg_mv);
          // settle countdown before a changed level commits
          if (m_pending == m_status[4]) begin
            m_settle = '0;
          end else if (m_settle != 0) begin
            m_settle = m_settle - 4'd1;
            commit = m_settle == 0;
          end else begin
            m_settle = 4'(SETTLE);
            commit = m_settle == 0;
          end
          if (commit) begin
            m_status[4] = m_pending;
            case (m_ctrl[5:4])
              EDGE_BOTH: trig = 1'b1;
              EDGE_NONE: trig = 1'b0;
              EDGE_FALL: trig = !m_pending;
              default:   trig = m_pending;
            endcase
            if (trig) m_status[0] = 1'b1;
            if (m_wired && m_ctrl[6]) begin
              r.ev_valid = 1'b1;
              r.ev_level = m_pending;
            end
          end
        end
      end
      OP_EVAL: begin
        if (block_active()) m_pending = compare_level(it.pos_mv, it.neg_mv);
      end
      OP_IRQ_ACK: begin
        if (m_inten[0] && m_status[0]) begin
          m_status[0] = 1'b0;
          r.taken = 1'b1;
        end
      end
      default: ;
    endcase
    r.irq = m_inten[0] & m_status[0];
    r.pos_sel = m_mux[5:3];
    r.neg_sel = m_mux[1:0];
    return r;
  endfunction

  // input driver: next beat once the current one is taken, idle bursts in between
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        in_gap = $urandom_range(16);
        in_valid <= 1'b0;
      end else begin
        beat = pending_q.pop_front();
        in_valid <= 1'b1;
        in_op <= beat.op;
        in_reg_index <= beat.reg_index;
        in_wdata <= beat.wdata;
        in_pos_mv <= beat.pos_mv;
        in_neg_mv <= beat.neg_mv;
      end
    end
  end

  // result stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(16);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: check result beats, then predict from accepted input beats
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          report_mismatch("result beat with nothing expected", int'(out_rdata), 0);
        end else begin
          want = result_q.pop_front();
          if (out_rdata !== want.rdata)
            report_mismatch("rdata", int'(out_rdata), int'(want.rdata));
          if (out_irq !== want.irq)
            report_mismatch("irq", int'(out_irq), int'(want.irq));
          if (out_interrupt_taken !== want.taken)
            report_mismatch("interrupt_taken", int'(out_interrupt_taken), int'(want.taken));
          if (out_event_valid !== want.ev_valid)
            report_mismatch("event_valid", int'(out_event_valid), int'(want.ev_valid));
          if (out_event_level !== want.ev_level)
            report_mismatch("event_level", int'(out_event_level), int'(want.ev_level));
          if (out_pos_select !== want.pos_sel)
            report_mismatch("pos_select", int'(out_pos_select), int'(want.pos_sel));
          if (out_neg_select !== want.neg_sel)
            report_mismatch("neg_select", int'(out_neg_select), int'(want.neg_sel));
        end
      end
      if (in_valid && !in_stall) begin
        seen = '{op: in_op, reg_index: in_reg_index, wdata: in_wdata,
                 pos_mv: in_pos_mv, neg_mv: in_neg_mv};
        result_q.push_back(comparator_step(seen));
      end
    end
  end

  task automatic add_item(input logic [2:0] op, input logic [2:0] idx, input logic [7:0] wd,
                          input logic [12:0] pos, input logic [12:0] neg);
    bus_item_t it;
    it = '{op: op, reg_index: idx, wdata: wd, pos_mv: pos, neg_mv: neg};
    if (op == OP_WRITE && idx == REG_MUX) gen_mux = wd;
    if (op == OP_WRITE && idx == REG_DAC) gen_dac = wd;
    pending_q.push_back(it);
  endtask

  // a voltage close to the threshold most of the time, else anywhere
  function automatic logic [12:0] near_mv(input int center);
    int v;
    if ($urandom_range(3) == 0) return 13'($urandom_range(8191));
    v = center + int'($urandom_range(140)) - 70;
    if (v < 0) v = 0;
    else if (v > 8191) v = 8191;
    return 13'(v);
  endfunction

  // mostly runs of ticks around the threshold, mixed with bus traffic
  task automatic add_random_items(input int count);
    int          made;
    int          run_len;
    int          center;
    int          pick;
    logic [12:0] pos;
    logic [12:0] neg;
    logic [2:0]  idx;
    logic [7:0]  wd;
    made = 0;
    wd = 8'($urandom_range(255));
    wd[0] = 1'b1;
    wd[3] = 1'b0;
    add_item(OP_WRITE, REG_CTRL, wd, 13'($urandom_range(8191)), 13'($urandom_range(8191)));
    made++;
    while (made < count) begin
      if ($urandom_range(99) < 55) begin
        neg = 13'($urandom_range(8191));
        if (gen_mux[1:0] == NEG_SEL_DAC) center = (int'(gen_dac) * int'(gen_vref)) / 256;
        else center = int'(neg);
        pos = near_mv(center);
        run_len = $urandom_range(6, 1);
        repeat (run_len) begin
          if ($urandom_range(4) == 0) pos = near_mv(center);
          add_item(OP_TICK, 3'($urandom_range(7)), 8'($urandom_range(255)), pos, neg);
          made++;
        end
      end else begin
        pick = $urandom_range(99);
        if (pick < 30) begin
          if ($urandom_range(99) < 85) idx = 3'($urandom_range(REG_STATUS, REG_CTRL));
          else idx = 3'($urandom_range(REG_LAST_UNUSED, REG_FIRST_UNUSED));
          wd = 8'($urandom_range(255));
          if (idx == REG_CTRL && $urandom_range(99) < 80) begin
            wd[0] = 1'b1;
            wd[3] = 1'b0;
          end
          add_item(OP_WRITE, idx, wd, 13'($urandom_range(8191)), 13'($urandom_range(8191)));
        end else if (pick < 48) begin
          add_item(OP_READ, 3'($urandom_range(7)), 8'($urandom_range(255)),
                   13'($urandom_range(8191)), 13'($urandom_range(8191)));
        end else if (pick < 60) begin
          add_item(OP_IRQ_ACK, 3'($urandom_range(7)), 8'($urandom_range(255)),
                   13'($urandom_range(8191)), 13'($urandom_range(8191)));
        end else if (pick < 70) begin
          add_item(OP_EVAL, 3'($urandom_range(7)), 8'($urandom_range(255)),
                   13'($urandom_range(8191)), 13'($urandom_range(8191)));
        end else if (pick < 76) begin
          add_item(3'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED)),
                   3'($urandom_range(7)), 8'($urandom_range(255)),
                   13'($urandom_range(8191)), 13'($urandom_range(8191)));
        end else begin
          add_item(OP_TICK, 3'($urandom_range(7)), 8'($urandom_range(255)),
                   13'($urandom_range(8191)), 13'($urandom_range(8191)));
        end
        made++;
      end
    end
  endtask

  // wait for every beat to go in and every result to come out
  task automatic wait_drained();
    do @(posedge clk); while (pending_q.size() != 0 || in_valid || result_q.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [12:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_VREF_MV) m_vref = val;
    else m_wired = val[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [12:0] vref, input logic wired, input int count,
                           input int in_pct, input int st_pct);
    wait_drained();
    write_cfg(CFG_VREF_MV, vref);
    write_cfg(CFG_EV_WIRED, {12'd0, wired});
    gen_vref = vref;
    idle_pct = in_pct;
    stall_pct = st_pct;
    add_random_items(count);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_cfg(CFG_EV_WIRED, 13'd1);
    idle_pct = 20;
    stall_pct = 20;

    // dac reset value, unused index and unused op with all fields high
    add_item(OP_READ, REG_DAC, 8'h00, 13'd0, 13'd0);
    add_item(OP_READ, REG_FIRST_UNUSED, 8'hFF, 13'd8191, 13'd8191);
    add_item(OP_LAST_UNUSED, REG_LAST_UNUSED, 8'hFF, 13'd8191, 13'd8191);
    // enable, no hysteresis, flag on both edges, event out
    add_item(OP_WRITE, REG_INTCTRL, 8'h01, 13'd0, 13'd0);
    add_item(OP_WRITE, REG_MUX, 8'h38, 13'd0, 13'd0);
    add_item(OP_WRITE, REG_CTRL, 8'h41, 13'd0, 13'd0);
    // rising level settles and commits on the third tick
    repeat (3) add_item(OP_TICK, REG_CTRL, 8'h00, 13'd8191, 13'd0);
    add_item(OP_READ, REG_STATUS, 8'h00, 13'd0, 13'd0);
    // ack takes the pending request, a second ack finds none
    add_item(OP_IRQ_ACK, REG_CTRL, 8'h00, 13'd0, 13'd0);
    add_item(OP_IRQ_ACK, REG_CTRL, 8'h00, 13'd0, 13'd0);
    // 50 mV hysteresis, rising edge only: inside the band keeps the level
    add_item(OP_WRITE, REG_CTRL, 8'h37, 13'd0, 13'd0);
    add_item(OP_TICK, REG_CTRL, 8'h00, 13'd100, 13'd140);
    // a change that reverts before settling
    add_item(OP_TICK, REG_CTRL, 8'h00, 13'd0, 13'd8191);
    add_item(OP_TICK, REG_CTRL, 8'h00, 13'd8191, 13'd0);
    add_item(OP_EVAL, REG_CTRL, 8'h00, 13'd0, 13'd8191);
    // inverted output against the dac at zero
    add_item(OP_WRITE, REG_MUX, 8'h83, 13'd0, 13'd0);
    add_item(OP_WRITE, REG_DAC, 8'h00, 13'd0, 13'd0);
    add_item(OP_TICK, REG_CTRL, 8'h00, 13'd0, 13'd0);
    // held block ignores ticks
    add_item(OP_WRITE, REG_CTRL, 8'h09, 13'd0, 13'd0);
    add_item(OP_TICK, REG_CTRL, 8'h00, 13'd0, 13'd8191);
    // flag clear by status write, unused index write ignored
    add_item(OP_WRITE, REG_STATUS, 8'hFF, 13'd0, 13'd0);
    add_item(OP_WRITE, REG_FIRST_UNUSED + 3'd1, 8'hFF, 13'd0, 13'd0);
    add_item(OP_READ, REG_STATUS, 8'h00, 13'd0, 13'd0);

    run_phase(13'd0, 1'b1, 320, 10, 10);
    run_phase(13'd8191, 1'b0, 320, 25, 5);
    run_phase(VREF_RESET, 1'b1, 320, 5, 30);
    run_phase(13'($urandom_range(8191)), 1'b1, 320, 15, 15);
    run_phase(13'd1, 1'b0, 300, 10, 0);
    run_phase(13'd3300, 1'b1, 370, 0, 0);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
